// ===== hw/rtl/ths_pkg.sv =====
// ----------------------------------------------------------------------------
// ths_pkg: two-axis homing sequencer definitions
// Item types, command and register codes, phase encoding and fixed limits.
// ----------------------------------------------------------------------------
package ths_pkg;

	// fixed sequence limits
	localparam logic [31:0]        Z_TIMEOUT_MS  = 32'd5000;
	localparam logic [31:0]        X_TIMEOUT_MS  = 32'd75000;
	localparam logic signed [31:0] SEEK_DISTANCE = -32'sd50000;

	// register reset values
	localparam logic [19:0] Z_SEEK_SPEED_RST = 20'd450;
	localparam logic [19:0] X_SEEK_SPEED_RST = 20'd800;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_Z_SEEK_SPEED      = 3'd0,
		REG_X_SEEK_SPEED      = 3'd1,
		REG_Z_TRAVEL_SPEED    = 3'd2,
		REG_X_TRAVEL_SPEED    = 3'd3,
		REG_Z_OFFSET_POSITION = 3'd4,
		REG_X_HOME_POSITION   = 3'd5,
		REG_X_PICKUP_POSITION = 3'd6
	} reg_idx_t;

	// command codes
	typedef enum logic [1:0] {
		CMD_NONE      = 2'd0,
		CMD_SEEK      = 2'd1,
		CMD_STOP      = 2'd2,
		CMD_HOME_MOVE = 2'd3
	} cmd_t;

	localparam logic AXIS_Z = 1'b0;
	localparam logic AXIS_X = 1'b1;

	// sequence phases, one-hot
	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_Z_SEEK = 5'b00010,
		PH_Z_MOVE = 5'b00100,
		PH_X_SEEK = 5'b01000,
		PH_X_MOVE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        z_switch;
		logic        x_switch;
		logic        z_at_target;
		logic        x_at_target;
	} poll_t;

	typedef struct packed {
		logic [1:0]         command;
		logic               command_axis;
		logic [19:0]        command_speed;
		logic signed [31:0] command_set_position;
		logic signed [31:0] command_target;
		logic               safe_outputs_off;
		logic               done_res;
		logic               fault;
	} result_t;

	typedef struct packed {
		logic [19:0]        z_seek_speed;
		logic [19:0]        x_seek_speed;
		logic [19:0]        z_travel_speed;
		logic [19:0]        x_travel_speed;
		logic signed [31:0] z_offset_position;
		logic signed [31:0] x_home_position;
		logic signed [31:0] x_pickup_position;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] z_seek_start_ms;
		logic [31:0] x_seek_start_ms;
		logic        fault_latched;
	} seq_state_t;

endpackage

// ===== hw/rtl/ths_req_if.sv =====
// ----------------------------------------------------------------------------
// ths_req_if: poll channel
// Valid/ready channel that carries one poll item.
// ----------------------------------------------------------------------------
interface ths_req_if;
	import ths_pkg::*;

	logic  valid;
	logic  ready;
	poll_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ths_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ths_rsp_if: command channel
// Valid/ready channel that carries one command result item.
// ----------------------------------------------------------------------------
interface ths_rsp_if;
	import ths_pkg::*;

	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ths_step.sv =====
// ----------------------------------------------------------------------------
// ths_step: homing sequence step logic
// Decodes the phase for one poll, gives the command and the next state.
// ----------------------------------------------------------------------------
module ths_step #(
	parameter logic [31:0]        Z_TIMEOUT_MS  = ths_pkg::Z_TIMEOUT_MS,
	parameter logic [31:0]        X_TIMEOUT_MS  = ths_pkg::X_TIMEOUT_MS,
	parameter logic signed [31:0] SEEK_DISTANCE = ths_pkg::SEEK_DISTANCE
) (
	input  ths_pkg::poll_t      poll,
	input  ths_pkg::cfg_t       cfg,
	input  ths_pkg::seq_state_t cur,
	output ths_pkg::seq_state_t nxt,
	output ths_pkg::result_t    res
);
	import ths_pkg::*;

	logic [31:0] z_elapsed;
	logic [31:0] x_elapsed;
	logic        z_timeout;
	logic        x_timeout;

	// wrap-safe elapsed time of each seek
	assign z_elapsed = poll.now_ms - cur.z_seek_start_ms;
	assign x_elapsed = poll.now_ms - cur.x_seek_start_ms;
	assign z_timeout = (z_elapsed >= Z_TIMEOUT_MS);
	assign x_timeout = (x_elapsed >= X_TIMEOUT_MS);

	// phase decode
	always_comb begin
		nxt = cur;
		res = '0;
		if (!cur.fault_latched) begin
			case (cur.phase)
				PH_Z_SEEK: begin
					if (poll.z_switch) begin
						res.command        = CMD_HOME_MOVE;
						res.command_axis   = AXIS_Z;
						res.command_speed  = cfg.z_travel_speed;
						res.command_target = cfg.z_offset_position;
						nxt.phase          = PH_Z_MOVE;
					end else if (z_timeout) begin
						res.command       = CMD_STOP;
						res.command_axis  = AXIS_Z;
						nxt.fault_latched = 1'b1;
					end
				end
				PH_Z_MOVE: begin
					if (poll.z_at_target) begin
						res.command         = CMD_SEEK;
						res.command_axis    = AXIS_X;
						res.command_speed   = cfg.x_seek_speed;
						res.command_target  = SEEK_DISTANCE;
						nxt.x_seek_start_ms = poll.now_ms;
						nxt.phase           = PH_X_SEEK;
					end
				end
				PH_X_SEEK: begin
					if (poll.x_switch) begin
						res.command              = CMD_HOME_MOVE;
						res.command_axis         = AXIS_X;
						res.command_speed        = cfg.x_travel_speed;
						res.command_set_position = cfg.x_home_position;
						res.command_target       = cfg.x_pickup_position;
						nxt.phase                = PH_X_MOVE;
					end else if (x_timeout) begin
						res.command       = CMD_STOP;
						res.command_axis  = AXIS_X;
						nxt.fault_latched = 1'b1;
					end
				end
				PH_X_MOVE: begin
					if (poll.x_at_target) begin
						res.done_res = 1'b1;
						nxt.phase    = PH_START;
					end
				end
				default: begin
					// start of sequence: outputs safe, z seeks home
					res.safe_outputs_off = 1'b1;
					res.command          = CMD_SEEK;
					res.command_axis     = AXIS_Z;
					res.command_speed    = cfg.z_seek_speed;
					res.command_target   = SEEK_DISTANCE;
					nxt.z_seek_start_ms  = poll.now_ms;
					nxt.phase            = PH_Z_SEEK;
				end
			endcase
		end
		res.fault = nxt.fault_latched;
	end

endmodule

// ===== hw/rtl/two_axis_homing_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// two_axis_homing_sequencer_core: two-axis homing sequencer
// Poll in, one command item out per poll; Z homes first, then X.
// ----------------------------------------------------------------------------
// path: an accepted poll is held in the poll register, its command item in the
//   result register, which drives the command valid
// throughput: one poll per cycle unless the command side stalls; the phase
//   decode and seek timeout subtract and compare sit between these two registers
// reset: sequence returns to its start phase, fault clears, registers take
//   their reset values, both stages empty
module two_axis_homing_sequencer_core #(
	parameter logic [31:0]        Z_TIMEOUT_MS  = ths_pkg::Z_TIMEOUT_MS,
	parameter logic [31:0]        X_TIMEOUT_MS  = ths_pkg::X_TIMEOUT_MS,
	parameter logic signed [31:0] SEEK_DISTANCE = ths_pkg::SEEK_DISTANCE
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	ths_req_if.sink                               req,
	ths_rsp_if.source                             rsp,
	input  logic                                  cfg_we,
	input  logic [ths_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ths_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import ths_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	poll_t      poll_s1;
	logic       valid_s1;
	result_t    res;
	result_t    res_s2;
	logic       valid_s2;
	logic       out_free;
	logic       fire;

	// handshake: the result stage frees when empty or being taken
	assign out_free  = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || out_free;
	assign fire      = valid_s1 && out_free;

	assign rsp.valid   = valid_s2;
	assign rsp.payload = res_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.z_seek_speed      <= Z_SEEK_SPEED_RST;
			cfg_q.x_seek_speed      <= X_SEEK_SPEED_RST;
			cfg_q.z_travel_speed    <= '0;
			cfg_q.x_travel_speed    <= '0;
			cfg_q.z_offset_position <= '0;
			cfg_q.x_home_position   <= '0;
			cfg_q.x_pickup_position <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_Z_SEEK_SPEED:      cfg_q.z_seek_speed      <= cfg_data[19:0];
				REG_X_SEEK_SPEED:      cfg_q.x_seek_speed      <= cfg_data[19:0];
				REG_Z_TRAVEL_SPEED:    cfg_q.z_travel_speed    <= cfg_data[19:0];
				REG_X_TRAVEL_SPEED:    cfg_q.x_travel_speed    <= cfg_data[19:0];
				REG_Z_OFFSET_POSITION: cfg_q.z_offset_position <= cfg_data[31:0];
				REG_X_HOME_POSITION:   cfg_q.x_home_position   <= cfg_data[31:0];
				REG_X_PICKUP_POSITION: cfg_q.x_pickup_position <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// step logic
	ths_step #(
		.Z_TIMEOUT_MS  (Z_TIMEOUT_MS),
		.X_TIMEOUT_MS  (X_TIMEOUT_MS),
		.SEEK_DISTANCE (SEEK_DISTANCE)
	) u_step (
		.poll (poll_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	// stage valids and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			state_q.phase <= PH_START;
			state_q.z_seek_start_ms <= '0;
			state_q.x_seek_start_ms <= '0;
			state_q.fault_latched   <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			poll_s1 <= req.payload;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== tb/sv/ths_command_checker.sv =====
// ----------------------------------------------------------------------------
// ths_command_checker: homing command predictor and scoreboard
// Watches the poll, command and register write ports of the homing sequencer,
// predicts the command item for every accepted poll from a private copy of
// the sequence state and registers, and compares each accepted command item
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ths_command_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           poll_valid,
	input  logic                           poll_ready,
	input  ths_pkg::poll_t                 poll,
	input  logic                           cmd_valid,
	input  logic                           cmd_ready,
	input  ths_pkg::result_t               cmd,
	input  logic                           cfg_we,
	input  logic [ths_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ths_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             outstanding
);
	import ths_pkg::*;

	// shadow of the sequencer
	cfg_t        regs;
	phase_t      phase_q;
	logic [31:0] z_start_q;
	logic [31:0] x_start_q;
	logic        fault_q;

	result_t     expected_cmds[$];
	int          errors;

	// next command for one poll, advances the shadow sequence
	function automatic result_t step_sequence(input poll_t p);
		result_t     r;
		logic [31:0] elapsed;
		r = '0;
		elapsed = '0;
		if (!fault_q) begin
			case (phase_q)
				PH_Z_SEEK: begin
					elapsed = p.now_ms - z_start_q;
					if (p.z_switch) begin
						r.command        = CMD_HOME_MOVE;
						r.command_axis   = AXIS_Z;
						r.command_speed  = regs.z_travel_speed;
						r.command_target = regs.z_offset_position;
						phase_q = PH_Z_MOVE;
					end else if (elapsed >= Z_TIMEOUT_MS) begin
						r.command      = CMD_STOP;
						r.command_axis = AXIS_Z;
						fault_q = 1'b1;
					end
				end
				PH_Z_MOVE: begin
					if (p.z_at_target) begin
						r.command        = CMD_SEEK;
						r.command_axis   = AXIS_X;
						r.command_speed  = regs.x_seek_speed;
						r.command_target = SEEK_DISTANCE;
						x_start_q = p.now_ms;
						phase_q = PH_X_SEEK;
					end
				end
				PH_X_SEEK: begin
					elapsed = p.now_ms - x_start_q;
					if (p.x_switch) begin
						r.command              = CMD_HOME_MOVE;
						r.command_axis         = AXIS_X;
						r.command_speed        = regs.x_travel_speed;
						r.command_set_position = regs.x_home_position;
						r.command_target       = regs.x_pickup_position;
						phase_q = PH_X_MOVE;
					end else if (elapsed >= X_TIMEOUT_MS) begin
						r.command      = CMD_STOP;
						r.command_axis = AXIS_X;
						fault_q = 1'b1;
					end
				end
				PH_X_MOVE: begin
					if (p.x_at_target) begin
						r.done_res = 1'b1;
						phase_q = PH_START;
					end
				end
				// start phase and any stray code: open the Z seek
				default: begin
					r.safe_outputs_off = 1'b1;
					r.command          = CMD_SEEK;
					r.command_axis     = AXIS_Z;
					r.command_speed    = regs.z_seek_speed;
					r.command_target   = SEEK_DISTANCE;
					z_start_q = p.now_ms;
					phase_q = PH_Z_SEEK;
				end
			endcase
		end
		r.fault = fault_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs = '0;
			regs.z_seek_speed = Z_SEEK_SPEED_RST;
			regs.x_seek_speed = X_SEEK_SPEED_RST;
			phase_q   = PH_START;
			z_start_q = '0;
			x_start_q = '0;
			fault_q   = 1'b0;
			expected_cmds.delete();
			errors = 0;
		end else begin
			// register writes, speeds keep their low 20 bits
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_Z_SEEK_SPEED:      regs.z_seek_speed      = cfg_data[19:0];
					REG_X_SEEK_SPEED:      regs.x_seek_speed      = cfg_data[19:0];
					REG_Z_TRAVEL_SPEED:    regs.z_travel_speed    = cfg_data[19:0];
					REG_X_TRAVEL_SPEED:    regs.x_travel_speed    = cfg_data[19:0];
					REG_Z_OFFSET_POSITION: regs.z_offset_position = cfg_data;
					REG_X_HOME_POSITION:   regs.x_home_position   = cfg_data;
					REG_X_PICKUP_POSITION: regs.x_pickup_position = cfg_data;
					default: ;
				endcase
			end

			// accepted command item against the oldest prediction
			if (cmd_valid && cmd_ready) begin
				if (expected_cmds.size() == 0) begin
					if (errors < 10)
						$display("%0t: command item with nothing expected", $realtime);
					errors++;
				end else begin
					want = expected_cmds.pop_front();
					if (cmd !== want) begin
						if (errors < 10) begin
							$display("%0t: command mismatch", $realtime);
							$display("  expected cmd=%0d axis=%0d speed=%0d setpos=%0d target=%0d safe=%0d done=%0d fault=%0d",
								want.command, want.command_axis, want.command_speed,
								want.command_set_position, want.command_target,
								want.safe_outputs_off, want.done_res, want.fault);
							$display("  actual   cmd=%0d axis=%0d speed=%0d setpos=%0d target=%0d safe=%0d done=%0d fault=%0d",
								cmd.command, cmd.command_axis, cmd.command_speed,
								cmd.command_set_position, cmd.command_target,
								cmd.safe_outputs_off, cmd.done_res, cmd.fault);
						end
						errors++;
					end
				end
			end

			// accepted poll item
			if (poll_valid && poll_ready)
				expected_cmds.push_back(step_sequence(poll));
		end
		fail_count  <= errors;
		outstanding <= expected_cmds.size();
	end

endmodule

// ===== tb/sv/two_axis_homing_sequencer_core_test.sv =====
// ----------------------------------------------------------------------------
// two_axis_homing_sequencer_core_test: homing sequencer regression
// Drives polls through a full homing pass with wrap and timeout edges, then
// random polls under four register settings, and ends with a seek timeout on
// a randomly chosen axis. Both channels idle at random; the checker predicts
// and compares every command item.
// ----------------------------------------------------------------------------
module two_axis_homing_sequencer_core_test;
	import ths_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  calm;
	int                    fail_count;
	int                    outstanding;

	ths_req_if poll_ch ();
	ths_rsp_if cmd_ch ();

	two_axis_homing_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (poll_ch),
		.rsp       (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ths_command_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll_valid  (poll_ch.valid),
		.poll_ready  (poll_ch.ready),
		.poll        (poll_ch.payload),
		.cmd_valid   (cmd_ch.valid),
		.cmd_ready   (cmd_ch.ready),
		.cmd         (cmd_ch.payload),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// command side stalls, none during the calm stretch
	always @(posedge clk) begin
		cmd_ch.ready <= calm || ($urandom_range(99) >= 11);
	end

	// run limit
	initial begin
		#400000;
		$display("two_axis_homing_sequencer_core regression: fail");
		$finish;
	end

	function automatic poll_t make_poll(input logic [31:0] t, input logic zs, input logic xs,
			input logic za, input logic xa);
		poll_t p;
		p.now_ms      = t;
		p.z_switch    = zs;
		p.x_switch    = xs;
		p.z_at_target = za;
		p.x_at_target = xa;
		return p;
	endfunction

	// one poll item, with an occasional idle cycle ahead of it
	task automatic send_poll(input poll_t p);
		if (!calm && $urandom_range(99) < 11) begin
			poll_ch.valid   <= 1'b0;
			poll_ch.payload <= make_poll($urandom, 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
			@(posedge clk);
		end
		poll_ch.valid   <= 1'b1;
		poll_ch.payload <= p;
		do @(posedge clk); while (!poll_ch.ready);
	endtask

	// stop polling and wait for every command item
	task automatic drain();
		poll_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] zs, input logic [31:0] xs,
			input logic [31:0] zt, input logic [31:0] xt, input logic [31:0] zo,
			input logic [31:0] xh, input logic [31:0] xp);
		write_reg(REG_Z_SEEK_SPEED, zs);
		write_reg(REG_X_SEEK_SPEED, xs);
		write_reg(REG_Z_TRAVEL_SPEED, zt);
		write_reg(REG_X_TRAVEL_SPEED, xt);
		write_reg(REG_Z_OFFSET_POSITION, zo);
		write_reg(REG_X_HOME_POSITION, xh);
		write_reg(REG_X_PICKUP_POSITION, xp);
		cfg_we <= 1'b0;
	endtask

	// random polls: small time steps with random flags, and now and then a
	// time jump with both switches tripped so an open seek closes first
	task automatic random_polls(inout logic [31:0] now_ms, input int count);
		poll_t p;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 10) begin
				now_ms = $urandom;
				p = make_poll(now_ms, 1'b1, 1'b1, 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else begin
				now_ms = now_ms + $urandom_range(40);
				p = make_poll(now_ms, $urandom_range(99) < 25, $urandom_range(99) < 25,
					$urandom_range(99) < 30, $urandom_range(99) < 30);
			end
			send_poll(p);
		end
	endtask

	initial begin
		logic [31:0] t;
		logic [31:0] limit;
		logic        pick_x;

		arst_n          = 1'b0;
		calm            = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		poll_ch.valid   = 1'b0;
		poll_ch.payload = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full pass at reset settings, seek windows straddle the time wrap
		t = 32'hFFFF_FF00;
		send_poll(make_poll(t, 1'b0, 1'b0, 1'b0, 1'b0));
		send_poll(make_poll(t + Z_TIMEOUT_MS - 1, 1'b0, 1'b0, 1'b0, 1'b0));
		// switch and timeout on the same poll: switch wins
		send_poll(make_poll(t + Z_TIMEOUT_MS, 1'b1, 1'b1, 1'b1, 1'b1));
		send_poll(make_poll(t + Z_TIMEOUT_MS, 1'b0, 1'b1, 1'b0, 1'b1));
		t = 32'hFFFF_FFFF;
		send_poll(make_poll(t, 1'b0, 1'b0, 1'b1, 1'b0));
		send_poll(make_poll(t + X_TIMEOUT_MS - 1, 1'b1, 1'b0, 1'b1, 1'b1));
		send_poll(make_poll(t + X_TIMEOUT_MS, 1'b1, 1'b1, 1'b0, 1'b0));
		send_poll(make_poll(32'h0, 1'b1, 1'b0, 1'b1, 1'b0));
		send_poll(make_poll(32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		// re-armed start ignores every flag
		send_poll(make_poll(32'h0, 1'b1, 1'b1, 1'b1, 1'b1));
		t = 32'h0;

		// low extremes
		drain();
		program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000);
		random_polls(t, 425);

		// high extremes, speed writes carry bits above the register width
		drain();
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		calm <= 1'b1;
		random_polls(t, 300);
		calm <= 1'b0;
		random_polls(t, 125);

		// random settings
		repeat (2) begin
			drain();
			program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			random_polls(t, 425);
		end

		// park in one seek, then let it time out
		pick_x = 1'($urandom_range(1));
		t = $urandom;
		limit = pick_x ? X_TIMEOUT_MS : Z_TIMEOUT_MS;
		send_poll(make_poll(t, 1'b1, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1))));
		repeat (5) send_poll(make_poll(t, pick_x, !pick_x, 1'b1, 1'b1));
		send_poll(make_poll(t + limit - 1, pick_x, !pick_x, 1'b1, 1'b1));
		send_poll(make_poll(t + limit, pick_x, !pick_x, 1'b0, 1'b0));
		// fault holds whatever comes in
		repeat (6) send_poll(make_poll($urandom, 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))));

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("two_axis_homing_sequencer_core regression: pass");
		else
			$display("two_axis_homing_sequencer_core regression: fail");
		$finish;
	end

endmodule
